@@ hw/rtl/dfpb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpb_pkg
// Shared types and constants of the dmx512 frame pulse builder.
// ----------------------------------------------------------------------------
package dfpb_pkg;

  // channels in one frame
  localparam int NUM_CHANNELS = 512;
  localparam int CNT_W        = 10;
  localparam logic [CNT_W-1:0] LAST_CHANNEL = CNT_W'(NUM_CHANNELS - 1);

  // request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAB_TIME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POST_IDLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_IDLE   = 3'd4;

  localparam logic [7:0]  RST_BIT_TIME   = 8'd4;
  localparam logic [15:0] RST_BREAK_TIME = 16'd120;
  localparam logic [15:0] RST_MAB_TIME   = 16'd12;
  localparam logic [15:0] RST_POST_IDLE  = 16'd50;
  localparam logic [15:0] RST_PRE_IDLE   = 16'd0;

  typedef struct packed {
    logic [7:0]  bit_time_us;
    logic [15:0] break_time_us;
    logic [15:0] mark_after_break_us;
    logic [15:0] post_idle_us;
    logic [15:0] pre_idle_us;
  } cfg_t;

  // one classified channel request
  typedef struct packed {
    logic [7:0] value;
    logic       first;
    logic       last;
  } cmd_t;

endpackage

@@ hw/rtl/dmx512_frame_pulse_builder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx512_frame_pulse_builder_unit
// DMX512 transmit framer: channel values in, line pulse records out.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  item      item_valid/item_stall  channel_value
//  record    rec_valid/rec_stall    line_level, pulse_len, frame_end, run_last
//  config    cfg_we                 cfg_index, cfg_data
//
//  a channel gives 10 records at one a cycle while rec_stall is low, 11
//  for the last channel, 22 to 23 for the first; the sequencer sets that rate.
//  a new channel is taken every cycle while the two-entry request queue
//  has room; the sequencer moves to the next request with no gap.
//  synchronous reset clears the channel counter, queue, sequencer and output
//  register, and loads the register defaults.
//  a stalled record holds in the output register; the front keeps taking
//  channels until the queue fills.
module dmx512_frame_pulse_builder_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dfpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfpb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [7:0]                     channel_value,
  output logic                           rec_valid,
  input  logic                           rec_stall,
  output logic                           line_level,
  output logic [15:0]                    pulse_len,
  output logic                           frame_end,
  output logic                           run_last
);
  import dfpb_pkg::*;

  cfg_t cfg;
  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_time_us         <= RST_BIT_TIME;
      cfg.break_time_us       <= RST_BREAK_TIME;
      cfg.mark_after_break_us <= RST_MAB_TIME;
      cfg.post_idle_us        <= RST_POST_IDLE;
      cfg.pre_idle_us         <= RST_PRE_IDLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_TIME:   cfg.bit_time_us         <= cfg_data[7:0];
        REG_BREAK_TIME: cfg.break_time_us       <= cfg_data;
        REG_MAB_TIME:   cfg.mark_after_break_us <= cfg_data;
        REG_POST_IDLE:  cfg.post_idle_us        <= cfg_data;
        REG_PRE_IDLE:   cfg.pre_idle_us         <= cfg_data;
        default: ;
      endcase
    end
  end

  dfpb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .channel_value (channel_value),
    .queue_full    (queue_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  dfpb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  dfpb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .line_level (line_level),
    .pulse_len  (pulse_len),
    .frame_end  (frame_end),
    .run_last   (run_last)
  );

endmodule

@@ hw/rtl/dfpb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpb_front
// Accepts channel values, tracks the channel counter and tags each request
// with its place in the frame.
// ----------------------------------------------------------------------------
module dfpb_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  logic [7:0]     channel_value,
  input  logic           queue_full,
  output logic           push,
  output dfpb_pkg::cmd_t push_cmd
);
  import dfpb_pkg::*;

  logic [CNT_W-1:0] channel_counter;
  logic [CNT_W-1:0] channel_counter_next;
  logic             is_last;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  // a counter past the end counts as the last channel
  assign is_last = (channel_counter >= LAST_CHANNEL);

  assign push_cmd.value = channel_value;
  assign push_cmd.first = (channel_counter == '0);
  assign push_cmd.last  = is_last;

  assign channel_counter_next = is_last ? '0 : channel_counter + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_counter <= '0;
    end else if (push) begin
      channel_counter <= channel_counter_next;
    end
  end

endmodule

@@ hw/rtl/dfpb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpb_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module dfpb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dfpb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dfpb_pkg::cmd_t head_cmd
);
  import dfpb_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

@@ hw/rtl/dfpb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpb_back
// Pulse sequencer: turns one queued request into its line pulse records,
// one record a cycle while not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module dfpb_back (
  input  logic           clk,
  input  logic           rst,
  input  dfpb_pkg::cfg_t cfg,
  input  logic           head_valid,
  input  dfpb_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           rec_valid,
  input  logic           rec_stall,
  output logic           line_level,
  output logic [15:0]    pulse_len,
  output logic           frame_end,
  output logic           run_last
);
  import dfpb_pkg::*;

  localparam logic [2:0] S_PRE   = 3'd0;
  localparam logic [2:0] S_BRK   = 3'd1;
  localparam logic [2:0] S_MAB   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_BIT   = 3'd4;
  localparam logic [2:0] S_STOP  = 3'd5;
  localparam logic [2:0] S_POST  = 3'd6;

  logic       busy;
  logic       busy_next;
  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] bit_idx;
  logic [2:0] bit_idx_next;
  logic       in_sc;
  logic       in_sc_next;
  cmd_t       cmd;

  logic        load_en;
  logic        emit;
  logic        rec_level;
  logic [15:0] rec_dur;
  logic        rec_end;
  logic        rec_last;
  logic [7:0]  tx_byte;
  logic [2:0]  start_state;

  assign load_en = !rec_valid || !rec_stall;
  assign emit    = busy && load_en;
  assign pop     = head_valid && (!busy || (emit && rec_last));

  // start code is a zero byte sent ahead of the first channel
  assign tx_byte = in_sc ? 8'd0 : cmd.value;

  always_comb begin
    if (!head_cmd.first) begin
      start_state = S_START;
    end else if (cfg.pre_idle_us != '0 && NUM_CHANNELS > 1) begin
      start_state = S_PRE;
    end else begin
      start_state = S_BRK;
    end
  end

  always_comb begin
    rec_level    = 1'b1;
    rec_dur      = 16'd0;
    rec_end      = 1'b0;
    rec_last     = 1'b0;
    state_next   = state;
    bit_idx_next = bit_idx;
    in_sc_next   = in_sc;
    busy_next    = busy;
    case (state)
      S_PRE: begin
        rec_dur    = cfg.pre_idle_us;
        state_next = S_BRK;
      end
      S_BRK: begin
        rec_level  = 1'b0;
        rec_dur    = cfg.break_time_us;
        state_next = S_MAB;
      end
      S_MAB: begin
        rec_dur    = cfg.mark_after_break_us;
        state_next = S_START;
        in_sc_next = 1'b1;
      end
      S_START: begin
        rec_level    = 1'b0;
        rec_dur      = {8'd0, cfg.bit_time_us};
        state_next   = S_BIT;
        bit_idx_next = 3'd0;
      end
      S_BIT: begin
        rec_level    = tx_byte[bit_idx];
        rec_dur      = {8'd0, cfg.bit_time_us};
        bit_idx_next = bit_idx + 3'd1;
        if (bit_idx == 3'd7) begin
          state_next = S_STOP;
        end
      end
      S_STOP: begin
        rec_dur = {7'd0, cfg.bit_time_us, 1'b0};
        if (in_sc) begin
          state_next = S_START;
          in_sc_next = 1'b0;
        end else if (cmd.last) begin
          state_next = S_POST;
        end else begin
          rec_last  = 1'b1;
          busy_next = 1'b0;
        end
      end
      S_POST: begin
        rec_dur   = cfg.post_idle_us;
        rec_end   = 1'b1;
        rec_last  = 1'b1;
        busy_next = 1'b0;
      end
      default: begin
        busy_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      state   <= S_BRK;
      bit_idx <= 3'd0;
      in_sc   <= 1'b0;
    end else if (pop) begin
      busy    <= 1'b1;
      state   <= start_state;
      bit_idx <= 3'd0;
      in_sc   <= 1'b0;
    end else if (emit) begin
      busy    <= busy_next;
      state   <= state_next;
      bit_idx <= bit_idx_next;
      in_sc   <= in_sc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head_cmd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (load_en) begin
      rec_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      line_level <= rec_level;
      pulse_len  <= rec_dur;
      frame_end  <= rec_end;
      run_last   <= rec_last;
    end
  end

  a_end_is_closing_mark: assert property (@(posedge clk) disable iff (rst)
    rec_valid && frame_end |-> line_level && run_last)
    else $error("frame end record must be a closing mark");

  a_stop_length: assert property (@(posedge clk) disable iff (rst)
    emit && state == S_STOP |=> pulse_len == {7'd0, cfg.bit_time_us, 1'b0})
    else $error("stop record length is not twice the bit time");

  a_pop_only_at_end: assert property (@(posedge clk) disable iff (rst)
    pop && busy |-> emit && (state == S_STOP || state == S_POST))
    else $error("next request taken before current one finished");

endmodule
